/* sv/frame_interval_pacer_macros.svh */
// assertion macros for the frame interval pacer
// expects clk and rst_n in the scope of the module that uses them
`ifndef FRAME_INTERVAL_PACER_MACROS_SVH
`define FRAME_INTERVAL_PACER_MACROS_SVH

// same-cycle implication, checked out of reset
`define FIP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FIP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/fip_pkg.sv */
// shared types and constants for the frame interval pacer
// no dependencies
`timescale 1ns / 1ps

package fip_pkg;

    localparam int TIME_W            = 48;
    localparam int MEAN_W            = 18;
    localparam int DELAY_W           = 21;
    localparam int FRAC_W            = 16;
    localparam int MULT_W            = 4;
    localparam int IDX_W             = 3;
    localparam int POS_W             = IDX_W + 1;
    localparam int FRAC_DIVIDEND_W   = POS_W + FRAC_W;
    localparam int HISTORY_DEPTH_DEF = 16;

    localparam logic [MEAN_W-1:0] MIN_INTERVAL_US = MEAN_W'(4000);
    localparam logic [MEAN_W-1:0] MAX_INTERVAL_US = MEAN_W'(200000);
    localparam logic [MULT_W-1:0] MULT_RESET      = MULT_W'(2);
    localparam logic [FRAC_W-1:0] FRAC_SAT        = '1;

    localparam logic REQ_PRESENT = 1'b0;
    localparam logic REQ_QUERY   = 1'b1;

    typedef enum logic [10:0] {
        S_IDLE       = 11'b000_0000_0001,
        S_CLAMP      = 11'b000_0000_0010,
        S_UPDATE     = 11'b000_0000_0100,
        S_MEAN_START = 11'b000_0000_1000,
        S_MEAN_WAIT  = 11'b000_0001_0000,
        S_DLY_START  = 11'b000_0010_0000,
        S_DLY_WAIT   = 11'b000_0100_0000,
        S_FRAC_START = 11'b000_1000_0000,
        S_FRAC_WAIT  = 11'b001_0000_0000,
        S_MUL        = 11'b010_0000_0000,
        S_OUT        = 11'b100_0000_0000
    } state_t;

endpackage

/* sv/fip_ring.sv */
// interval history memory, one write port and one registered read port
// depends on fip_pkg
`timescale 1ns / 1ps

module fip_ring
    import fip_pkg::*;
#(
    parameter int DEPTH  = HISTORY_DEPTH_DEF,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [MEAN_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [MEAN_W-1:0] rd_data
);

    logic [MEAN_W-1:0] mem [DEPTH];
    logic [MEAN_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/fip_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on fip_pkg
`timescale 1ns / 1ps

module fip_div
    import fip_pkg::*;
#(
    parameter int DIV_W = 22,
    parameter int VSR_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [VSR_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [VSR_W-1:0] rem_reg, rem_next;
    logic [VSR_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VSR_W:0]   rem_shift;
    logic [VSR_W:0]   diff;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // trial subtract, keep the remainder when it goes negative
            if (!diff[VSR_W])
            begin
                rem_next = diff[VSR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[VSR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/frame_interval_pacer.sv */
// a real present runs the divider for the mean, the per-frame slot and the fraction (DIV_W = 22 at 16 entries),
//   a query or the first present skips the mean; a multiplier of 1 skips the slot division, 0 also the fraction
// the input stalls outside idle, so a new transaction is taken only once the last one reaches the result register;
//   the shared one-bit-per-cycle divider is used in turn for the mean, the per-frame slot and the fraction
// reset: asynchronous active low, clears timing history, mean and control; multiplier is 2
// depends on fip_pkg, fip_ring, fip_div and frame_interval_pacer_macros.svh
`timescale 1ns / 1ps
`include "frame_interval_pacer_macros.svh"

module frame_interval_pacer
    import fip_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // input transaction
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [TIME_W-1:0]  timestamp_us,
    input  logic [IDX_W-1:0]   synth_index,
    // result transaction
    output logic               out_valid,
    input  logic               out_stall,
    output logic [MEAN_W-1:0]  mean_interval_us,
    output logic [DELAY_W-1:0] synth_delay_us,
    output logic [FRAC_W-1:0]  interp_fraction,
    // multiplier register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [MULT_W-1:0]  frame_multiplier
);

    // ring pointer, sample count and window sum widths follow the history depth
    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = $clog2(HISTORY_DEPTH * 200000 + 1);
    // divider must hold the window sum and the shifted frame position
    localparam int DIV_W = (SUM_W > FRAC_DIVIDEND_W) ? SUM_W : FRAC_DIVIDEND_W;
    localparam int VSR_W = (CNT_W > MULT_W) ? CNT_W : MULT_W;
    localparam int PROD_W = MEAN_W + POS_W;

    state_t state_reg, state_next;

    // timing history
    logic [TIME_W-1:0] prev_reg, prev_next;
    logic              have_prev_reg, have_prev_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [MEAN_W-1:0] mean_reg, mean_next;
    logic [MULT_W-1:0] mult_reg, mult_next;

    // per-transaction working values
    logic [TIME_W-1:0] delta_reg, delta_next;
    logic [MEAN_W-1:0] sample_reg, sample_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [MEAN_W-1:0] slot_reg, slot_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [MEAN_W-1:0]  out_mean_reg, out_mean_next;
    logic [DELAY_W-1:0] out_delay_reg, out_delay_next;
    logic [FRAC_W-1:0]  out_frac_reg, out_frac_next;

    // ring and divider hookup
    logic              ring_wr;
    logic [MEAN_W-1:0] ring_old;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [VSR_W-1:0]  div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;

    logic              in_fire;
    logic              full;
    logic [PROD_W-1:0] prod;
    logic              window_clear;

    assign in_fire      = in_valid && (state_reg == S_IDLE);
    assign in_stall     = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign full         = (count_reg == CNT_W'(HISTORY_DEPTH));
    assign prod         = slot_reg * pos_reg;
    assign window_clear = (sum_reg == '0) && (mean_reg == '0);

    fip_ring #(
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr),
        .wr_addr (ptr_reg),
        .wr_data (sample_reg),
        .rd_addr (ptr_reg),
        .rd_data (ring_old)
    );

    fip_div #(
        .DIV_W (DIV_W),
        .VSR_W (VSR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // divider operand select: mean, slot length, then fraction
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DIV_W'(sum_reg);
        div_divisor  = VSR_W'(count_reg);
        case (state_reg)
            S_MEAN_START:
            begin
                div_start = 1'b1;
            end
            S_DLY_START:
            begin
                div_start    = (mult_reg > MULT_W'(1));
                div_dividend = DIV_W'(mean_reg);
                div_divisor  = VSR_W'(mult_reg);
            end
            S_FRAC_START:
            begin
                div_start    = (mult_reg != '0);
                div_dividend = DIV_W'({pos_reg, {FRAC_W{1'b0}}});
                div_divisor  = VSR_W'(mult_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        mean_next      = mean_reg;
        mult_next      = mult_reg;
        delta_next     = delta_reg;
        sample_next    = sample_reg;
        pos_next       = pos_reg;
        slot_next      = slot_reg;
        frac_next      = frac_reg;
        delay_next     = delay_reg;
        out_valid_next = out_valid_reg;
        out_mean_next  = out_mean_reg;
        out_delay_next = out_delay_reg;
        out_frac_next  = out_frac_reg;
        ring_wr        = 1'b0;

        // register write, only while idle
        if (cfg_valid && cfg_ready)
        begin
            mult_next = frame_multiplier;
        end

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    pos_next   = POS_W'(synth_index) + POS_W'(1);
                    // wraps mod 2^48 by width
                    delta_next = timestamp_us - prev_reg;
                    state_next = S_DLY_START;
                    if (req_type == REQ_PRESENT)
                    begin
                        prev_next      = timestamp_us;
                        have_prev_next = 1'b1;
                        // first present records the time and skips the window update
                        if (have_prev_reg)
                        begin
                            state_next = S_CLAMP;
                        end
                    end
                end
            end
            S_CLAMP:
            begin
                if (delta_reg < TIME_W'(MIN_INTERVAL_US))
                begin
                    sample_next = MIN_INTERVAL_US;
                end
                else if (delta_reg > TIME_W'(MAX_INTERVAL_US))
                begin
                    sample_next = MAX_INTERVAL_US;
                end
                else
                begin
                    sample_next = delta_reg[MEAN_W-1:0];
                end
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                // ring_old holds the entry at the pointer, oldest once the ring is full
                ring_wr = 1'b1;
                if (full)
                begin
                    sum_next = sum_reg - SUM_W'(ring_old) + SUM_W'(sample_reg);
                end
                else
                begin
                    sum_next   = sum_reg + SUM_W'(sample_reg);
                    count_next = count_reg + CNT_W'(1);
                end
                if (ptr_reg == PTR_W'(HISTORY_DEPTH - 1))
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
                state_next = S_MEAN_START;
            end
            S_MEAN_START:
            begin
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    mean_next  = div_quo[MEAN_W-1:0];
                    state_next = S_DLY_START;
                end
            end
            S_DLY_START:
            begin
                if (mult_reg > MULT_W'(1))
                begin
                    state_next = S_DLY_WAIT;
                end
                else
                begin
                    slot_next  = '0;
                    state_next = S_FRAC_START;
                end
            end
            S_DLY_WAIT:
            begin
                if (div_done)
                begin
                    slot_next  = div_quo[MEAN_W-1:0];
                    state_next = S_FRAC_START;
                end
            end
            S_FRAC_START:
            begin
                if (mult_reg != '0)
                begin
                    state_next = S_FRAC_WAIT;
                end
                else
                begin
                    frac_next  = FRAC_SAT;
                    state_next = S_MUL;
                end
            end
            S_FRAC_WAIT:
            begin
                if (div_done)
                begin
                    // saturate once the position reaches a whole interval
                    if (div_quo[DIV_W-1:FRAC_W] != '0)
                    begin
                        frac_next = FRAC_SAT;
                    end
                    else
                    begin
                        frac_next = div_quo[FRAC_W-1:0];
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                delay_next = prod[DELAY_W-1:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_mean_next  = mean_reg;
                    out_delay_next = delay_reg;
                    out_frac_next  = frac_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            ptr_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            mean_reg      <= '0;
            mult_reg      <= MULT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            mean_reg      <= mean_next;
            mult_reg      <= mult_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg     <= delta_next;
        sample_reg    <= sample_next;
        pos_reg       <= pos_next;
        slot_reg      <= slot_next;
        frac_reg      <= frac_next;
        delay_reg     <= delay_next;
        out_mean_reg  <= out_mean_next;
        out_delay_reg <= out_delay_next;
        out_frac_reg  <= out_frac_next;
    end

    assign out_valid        = out_valid_reg;
    assign mean_interval_us = out_mean_reg;
    assign synth_delay_us   = out_delay_reg;
    assign interp_fraction  = out_frac_reg;

    // sample count never passes the ring depth
    `FIP_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(HISTORY_DEPTH), "count past depth")
    // an empty window has no sum and no mean
    `FIP_ASSERT_IMP(a_empty_window, count_reg == '0, window_clear, "empty window not clear")
    // mean of clamped samples stays in range
    `FIP_ASSERT_IMP(a_mean_bound, 1'b1, mean_reg <= MAX_INTERVAL_US, "mean above max interval")
    // a new transaction blocks the input in the next cycle
    `FIP_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open during work")
    // the divider is only started when free
    `FIP_ASSERT_IMP(a_div_start_free, div_start, !div_busy, "divider restarted while busy")

endmodule
